### hdl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg: shared types and constants
// Widths and the command/status structs between the controller and datapath.
// ----------------------------------------------------------------------------
package b2da_pkg;

	localparam int VALUE_W  = 32;
	localparam int DIGITS   = 10;
	localparam int BCD_W    = 4 * DIGITS;
	localparam int CHAR_W   = 6;
	localparam int CNT_W    = 4;
	localparam int BITCNT_W = 5;

	localparam logic [CNT_W-1:0]  DIGITS_CNT = CNT_W'(DIGITS);
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	typedef struct packed {
		logic load;   // take a new value, clear the BCD word
		logic shift;  // one double-dabble step
		logic skip;   // drop a leading zero digit
		logic pop;    // drop the digit just delivered
	} b2da_cmd_t;

	typedef struct packed {
		logic top_zero; // leading digit is zero
		logic cnt_one;  // one digit left
	} b2da_sts_t;

endpackage

### hdl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: 32-bit binary to decimal ASCII converter
// Prints an unsigned value as ASCII digits, most significant first, no
// leading zeros, with the final digit of each number marked.
// ----------------------------------------------------------------------------
//  channel | signals                    | direction | handshake
//  input   | value[31:0]                | in        | in_valid / in_stall
//  output  | digit_char[5:0], last      | out       | out_valid / out_stall
//
// An item passes through acceptance (load), one double-dabble shift step per
// value bit in the serial register, the trim (one step per leading zero dropped
// plus one to reach delivery) and one delivery step per digit. A digit waits
// while out_stall is high. One item is in work at a time; in_stall is high
// from the cycle after acceptance until its last digit is taken.
// Reset is asynchronous and clears the controller only.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii import b2da_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [VALUE_W-1:0]  value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CHAR_W-1:0]   digit_char,
	output logic                last
);

	b2da_cmd_t cmd;
	b2da_sts_t sts;

	b2da_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	b2da_dp u_dp (
		.clk        (clk),
		.value      (value),
		.cmd        (cmd),
		.sts        (sts),
		.digit_char (digit_char),
		.last       (last)
	);

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_char >= 6'd48 && digit_char <= 6'd57))
		else $error("digit out of range");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while digits pending");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !out_valid)
		else $error("result right after accept");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> (!out_valid && !in_stall))
		else $error("block not idle after last digit");

endmodule

### hdl/b2da_dp.sv
// ----------------------------------------------------------------------------
// b2da_dp: conversion datapath
// Serial double-dabble shifter, digit counter and output digit selection.
// ----------------------------------------------------------------------------
module b2da_dp import b2da_pkg::*; (
	input  logic                clk,
	input  logic [VALUE_W-1:0]  value,
	input  b2da_cmd_t           cmd,
	output b2da_sts_t           sts,
	output logic [CHAR_W-1:0]   digit_char,
	output logic                last
);

	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [BCD_W-1:0]   bcd_adj;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= value;
			bcd_q <= '0;
			cnt_q <= DIGITS_CNT;
		end else if (cmd.shift) begin
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
		end else if (cmd.skip || cmd.pop) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			cnt_q <= cnt_q - 4'd1;
		end
	end

	assign sts.top_zero = (bcd_q[BCD_W-1 -: 4] == 4'd0);
	assign sts.cnt_one  = (cnt_q == 4'd1);

	assign digit_char = ASCII_ZERO | {2'b00, bcd_q[BCD_W-1 -: 4]};
	assign last       = sts.cnt_one;

endmodule

### hdl/b2da_ctrl.sv
// ----------------------------------------------------------------------------
// b2da_ctrl: sequencing controller
// Steps through load, the shift loop, leading-zero trim and digit delivery.
// ----------------------------------------------------------------------------
module b2da_ctrl import b2da_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  b2da_sts_t  sts,
	output b2da_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_TRIM = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]          state_q;
	logic [BITCNT_W-1:0] bit_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);

	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == ST_IDLE) && in_valid;
		cmd.shift = (state_q == ST_CONV);
		cmd.skip  = (state_q == ST_TRIM) && sts.top_zero && !sts.cnt_one;
		cmd.pop   = (state_q == ST_EMIT) && !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					bit_q <= '0;
					if (in_valid) state_q <= ST_CONV;
				end
				ST_CONV: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == {BITCNT_W{1'b1}}) state_q <= ST_TRIM;
				end
				ST_TRIM: begin
					if (!cmd.skip) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// hold until the final digit is taken
					if (cmd.pop && sts.cnt_one) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
